/* design/bifc_pkg.sv */
// Package for the idle backlight fade controller: field widths, codes,
// configuration reset values and the structs shared by the modules.
// No dependencies.
`timescale 1ns / 1ps

package bifc_pkg;

   localparam int ACTION_W  = 2;
   localparam int TIME_W    = 32;
   localparam int MODE_W    = 4;
   localparam int LEVEL_W   = 7;
   localparam int TARGET_W  = 8;
   localparam int DELAY_S_W = 16;
   localparam int MS_PER_S_W = 10;
   localparam int DELAY_MS_W = DELAY_S_W + MS_PER_S_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [MS_PER_S_W-1:0] MS_PER_S       = 10'd1000;
   localparam logic [TIME_W-1:0]     STEP_PERIOD_MS = 32'd50;
   localparam logic [TIME_W-1:0]     TOUCH_GUARD_MS = 32'd500;
   localparam logic [MODE_W-1:0]     PLAYER_MODE    = 4'd0;
   localparam logic [LEVEL_W-1:0]    LEVEL_MAX      = 7'd100;
   localparam logic [LEVEL_W-1:0]    LEVEL_ONE      = 7'd1;

   localparam logic                  FADE_ENABLE_RST  = 1'b0;
   localparam logic [DELAY_MS_W-1:0] DELAY_MS_RST     = 26'd30000;
   localparam logic [TARGET_W-1:0]   DIM_TARGET_RST   = 8'd20;
   localparam logic [LEVEL_W-1:0]    FADE_STEP_RST    = 7'd1;
   localparam logic [LEVEL_W-1:0]    NORMAL_LEVEL_RST = 7'd100;

   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK       = 2'd0,
      ACT_WAKE       = 2'd1,
      ACT_TOUCH      = 2'd2,
      ACT_SET_ENABLE = 2'd3
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FADE_ENABLE  = 3'd0,
      CSR_IDLE_DELAY_S = 3'd1,
      CSR_DIM_TARGET   = 3'd2,
      CSR_FADE_STEP    = 3'd3,
      CSR_NORMAL_LEVEL = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_WAIT   = 3'b001,
      ST_FADING = 3'b010,
      ST_DIMMED = 3'b100
   } fade_state_type;

   typedef struct packed {
      fade_state_type       fade_state;
      logic                 level_captured;
      logic [LEVEL_W-1:0]   current_level;
      logic [LEVEL_W-1:0]   target_level;
      logic [TIME_W-1:0]    last_activity_ms;
      logic [TIME_W-1:0]    last_step_ms;
      logic [TIME_W-1:0]    last_wake_ms;
      logic [MODE_W-1:0]    prev_mode;
   } state_type;

   typedef struct packed {
      logic                  fade_enable;
      logic [DELAY_MS_W-1:0] delay_ms;
      logic [TARGET_W-1:0]   dim_target;
      logic [LEVEL_W-1:0]    fade_step;
      logic [LEVEL_W-1:0]    normal_level;
   } cfg_type;

   typedef struct packed {
      action_type          action;
      logic [TIME_W-1:0]   now_ms;
      logic                soft_ap;
      logic                display_ready;
      logic [MODE_W-1:0]   display_mode;
      logic                enable_value;
   } item_type;

   typedef struct packed {
      logic               drive_valid;
      logic [LEVEL_W-1:0] drive_level;
      logic               touch_consumed;
      logic               is_fading;
      logic               is_dimmed;
   } result_type;

endpackage

/* design/bifc_req_if.sv */
// Request channel of the backlight fade controller: valid/ready plus one
// input transaction. Depends on bifc_pkg for field widths.
`timescale 1ns / 1ps

interface bifc_req_if;
   logic                          valid;
   logic                          ready;
   logic [bifc_pkg::ACTION_W-1:0] action;
   logic [bifc_pkg::TIME_W-1:0]   now_ms;
   logic                          soft_ap;
   logic                          display_ready;
   logic [bifc_pkg::MODE_W-1:0]   display_mode;
   logic                          enable_value;

   modport source (
      output valid, action, now_ms, soft_ap, display_ready, display_mode, enable_value,
      input  ready
   );
   modport sink (
      input  valid, action, now_ms, soft_ap, display_ready, display_mode, enable_value,
      output ready
   );
endinterface

/* design/bifc_rsp_if.sv */
// Response channel of the backlight fade controller: valid/ready plus one
// result transaction. Depends on bifc_pkg for field widths.
`timescale 1ns / 1ps

interface bifc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         drive_valid;
   logic [bifc_pkg::LEVEL_W-1:0] drive_level;
   logic                         touch_consumed;
   logic                         is_fading;
   logic                         is_dimmed;

   modport source (
      output valid, drive_valid, drive_level, touch_consumed, is_fading, is_dimmed,
      input  ready
   );
   modport sink (
      input  valid, drive_valid, drive_level, touch_consumed, is_fading, is_dimmed,
      output ready
   );
endinterface

/* design/backlight_idle_fade_controller_unit.sv */
// Top level of the idle backlight fade controller; uses bifc_pkg, the two
// channel interfaces and bifc_step.
// A transaction is held in the input register and its result in the result register.
// Throughput: one transaction per cycle while results keep being taken; the state
// update for a transaction is a single combinational pass between the input and
// result registers.
// Reset (synchronous, active high) restores state and configuration defaults.
`timescale 1ns / 1ps

module backlight_idle_fade_controller_unit (
   input  logic                              clock,
   input  logic                              reset,
   bifc_req_if.sink                          req_bus,
   bifc_rsp_if.source                        rsp_bus,
   input  logic                              csr_we,
   input  logic [bifc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bifc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   // Configuration registers. The idle delay is kept in milliseconds; the
   // seconds-to-milliseconds product is formed once when the register is
   // written, so the per-transaction path only needs a subtract and compare.
   bifc_pkg::cfg_type cfg_ff, cfg_in;
   logic [bifc_pkg::DELAY_MS_W-1:0] delay_ms_wr;

   assign delay_ms_wr = {{bifc_pkg::MS_PER_S_W{1'b0}}, csr_wdata} *
                        {{bifc_pkg::DELAY_S_W{1'b0}}, bifc_pkg::MS_PER_S};

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            bifc_pkg::CSR_FADE_ENABLE:  cfg_in.fade_enable  = csr_wdata[0];
            bifc_pkg::CSR_IDLE_DELAY_S: cfg_in.delay_ms     = delay_ms_wr;
            bifc_pkg::CSR_DIM_TARGET:   cfg_in.dim_target   = csr_wdata[bifc_pkg::TARGET_W-1:0];
            bifc_pkg::CSR_FADE_STEP:    cfg_in.fade_step    = csr_wdata[bifc_pkg::LEVEL_W-1:0];
            bifc_pkg::CSR_NORMAL_LEVEL: cfg_in.normal_level = csr_wdata[bifc_pkg::LEVEL_W-1:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fade_enable  <= bifc_pkg::FADE_ENABLE_RST;
         cfg_ff.delay_ms     <= bifc_pkg::DELAY_MS_RST;
         cfg_ff.dim_target   <= bifc_pkg::DIM_TARGET_RST;
         cfg_ff.fade_step    <= bifc_pkg::FADE_STEP_RST;
         cfg_ff.normal_level <= bifc_pkg::NORMAL_LEVEL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input register. It empties whenever its transaction moves to the
   // result register, so a new transaction is taken every cycle as long as
   // the result side keeps draining.
   logic                 in_valid_ff, in_valid_in;
   bifc_pkg::item_type   in_item_ff, in_item_in;
   logic                 advance;
   logic                 req_take;

   assign advance       = in_valid_ff && (!rsp_bus.valid || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      in_item_in.action        = bifc_pkg::action_type'(req_bus.action);
      in_item_in.now_ms        = req_bus.now_ms;
      in_item_in.soft_ap       = req_bus.soft_ap;
      in_item_in.display_ready = req_bus.display_ready;
      in_item_in.display_mode  = req_bus.display_mode;
      in_item_in.enable_value  = req_bus.enable_value;
      in_valid_in              = req_take || (in_valid_ff && !advance);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= in_item_in;
      end
   end

   // Controller state. It is updated in the same cycle the transaction's
   // result is written, so the next transaction already sees it.
   bifc_pkg::state_type  state_ff, state_in;
   bifc_pkg::result_type res_in;

   bifc_step u_step (
      .cur  (state_ff),
      .cfg  (cfg_ff),
      .item (in_item_ff),
      .nxt  (state_in),
      .res  (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.fade_state       <= bifc_pkg::ST_WAIT;
         state_ff.level_captured   <= 1'b0;
         state_ff.current_level    <= '0;
         state_ff.target_level     <= '0;
         state_ff.last_activity_ms <= '0;
         state_ff.last_step_ms     <= '0;
         state_ff.last_wake_ms     <= '0;
         state_ff.prev_mode        <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register: holds one finished transaction until it is taken.
   logic                 out_valid_ff, out_valid_in;
   bifc_pkg::result_type out_res_ff;

   assign out_valid_in = advance || (out_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_res_ff <= res_in;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.drive_valid    = out_res_ff.drive_valid;
   assign rsp_bus.drive_level    = out_res_ff.drive_level;
   assign rsp_bus.touch_consumed = out_res_ff.touch_consumed;
   assign rsp_bus.is_fading      = out_res_ff.is_fading;
   assign rsp_bus.is_dimmed      = out_res_ff.is_dimmed;

endmodule

/* design/bifc_step.sv */
// Next-state and result logic for one transaction of the fade controller.
// Purely combinational; depends on bifc_pkg.
`timescale 1ns / 1ps

module bifc_step (
   input  bifc_pkg::state_type  cur,
   input  bifc_pkg::cfg_type    cfg,
   input  bifc_pkg::item_type   item,
   output bifc_pkg::state_type  nxt,
   output bifc_pkg::result_type res
);

   logic [bifc_pkg::LEVEL_W-1:0] user_level;
   logic [bifc_pkg::LEVEL_W-1:0] clamp_target;
   logic                         wake_drive;
   bifc_pkg::state_type          woken;
   logic                         mode_change;
   bifc_pkg::state_type          base;
   logic                         can_capture;
   logic [bifc_pkg::LEVEL_W-1:0] cap_level;
   logic [bifc_pkg::TIME_W-1:0]  since_activity;
   logic [bifc_pkg::TIME_W-1:0]  since_step;
   logic [bifc_pkg::TIME_W-1:0]  since_wake;
   logic [bifc_pkg::LEVEL_W-1:0] step_size;
   logic [bifc_pkg::LEVEL_W-1:0] remaining;
   logic [bifc_pkg::LEVEL_W-1:0] decrement;
   logic [bifc_pkg::LEVEL_W-1:0] faded_level;
   logic                         drv_valid;
   logic [bifc_pkg::LEVEL_W-1:0] drv_level;
   logic                         consumed;

   assign user_level   = (cfg.normal_level > bifc_pkg::LEVEL_MAX) ?
                         bifc_pkg::LEVEL_MAX : cfg.normal_level;
   assign clamp_target = (cfg.dim_target > {1'b0, bifc_pkg::LEVEL_MAX}) ?
                         bifc_pkg::LEVEL_MAX : cfg.dim_target[bifc_pkg::LEVEL_W-1:0];

   // A wake restores the user brightness when a captured level differs from it.
   assign wake_drive = cur.level_captured && (cur.current_level != user_level);
   always_comb begin
      woken                  = cur;
      woken.last_wake_ms     = item.now_ms;
      woken.last_activity_ms = item.now_ms;
      woken.level_captured   = 1'b0;
      woken.fade_state       = bifc_pkg::ST_WAIT;
   end

   // A ready tick with fading enabled that sees a new display mode wakes first and then goes on.
   assign mode_change = item.display_mode != cur.prev_mode;
   always_comb begin
      base = mode_change ? woken : cur;
      base.prev_mode = item.display_mode;
   end

   assign can_capture = !base.level_captured && (user_level != '0);
   assign cap_level   = can_capture ? user_level : base.current_level;

   assign since_activity = item.now_ms - base.last_activity_ms;
   assign since_step     = item.now_ms - base.last_step_ms;
   assign since_wake     = item.now_ms - cur.last_wake_ms;

   assign step_size   = (cfg.fade_step == '0) ? bifc_pkg::LEVEL_ONE : cfg.fade_step;
   assign remaining   = cap_level - base.target_level;
   assign decrement   = (step_size < remaining) ? step_size : remaining;
   assign faded_level = cap_level - decrement;

   always_comb begin
      nxt       = cur;
      drv_valid = 1'b0;
      drv_level = '0;
      consumed  = 1'b0;
      unique case (item.action)
         bifc_pkg::ACT_TICK: begin
            if (!item.soft_ap && item.display_ready) begin
               if (!cfg.fade_enable) begin
                  if (cur.fade_state != bifc_pkg::ST_WAIT) begin
                     nxt       = woken;
                     drv_valid = wake_drive;
                  end
               end else begin
                  nxt       = base;
                  drv_valid = mode_change && wake_drive;
                  if (item.display_mode == bifc_pkg::PLAYER_MODE) begin
                     nxt.current_level  = cap_level;
                     nxt.level_captured = base.level_captured || can_capture;
                     if (base.fade_state == bifc_pkg::ST_WAIT) begin
                        if (since_activity > {{(bifc_pkg::TIME_W - bifc_pkg::DELAY_MS_W){1'b0}},
                                              cfg.delay_ms}) begin
                           nxt.target_level = clamp_target;
                           if (cap_level <= clamp_target) begin
                              nxt.fade_state = bifc_pkg::ST_DIMMED;
                           end else begin
                              nxt.fade_state   = bifc_pkg::ST_FADING;
                              nxt.last_step_ms = item.now_ms;
                           end
                        end
                     end else if (base.fade_state == bifc_pkg::ST_FADING) begin
                        if (since_step >= bifc_pkg::STEP_PERIOD_MS) begin
                           nxt.last_step_ms = item.now_ms;
                           if (cap_level > base.target_level) begin
                              nxt.current_level = faded_level;
                              drv_valid         = 1'b1;
                              if (faded_level == base.target_level) begin
                                 nxt.fade_state = bifc_pkg::ST_DIMMED;
                              end
                           end else begin
                              nxt.fade_state = bifc_pkg::ST_DIMMED;
                           end
                        end
                     end
                  end
               end
            end
            // Only a wake can drive on this path unless a fade step happened.
            drv_level = (drv_valid && (nxt.fade_state != bifc_pkg::ST_WAIT)) ?
                        nxt.current_level : user_level;
         end
         bifc_pkg::ACT_WAKE: begin
            nxt       = woken;
            drv_valid = wake_drive;
            drv_level = user_level;
         end
         bifc_pkg::ACT_TOUCH: begin
            drv_level = user_level;
            if (cfg.fade_enable) begin
               if (cur.fade_state != bifc_pkg::ST_WAIT) begin
                  nxt       = woken;
                  drv_valid = wake_drive;
                  consumed  = 1'b1;
               end else begin
                  nxt.last_activity_ms = item.now_ms;
                  consumed = since_wake < bifc_pkg::TOUCH_GUARD_MS;
               end
            end
         end
         bifc_pkg::ACT_SET_ENABLE: begin
            drv_level          = user_level;
            nxt.level_captured = 1'b0;
            nxt.fade_state     = bifc_pkg::ST_WAIT;
            if (!item.enable_value) begin
               drv_valid = cur.level_captured;
            end else begin
               drv_valid            = wake_drive;
               nxt.last_activity_ms = item.now_ms;
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

   always_comb begin
      res.drive_valid    = drv_valid;
      res.drive_level    = drv_valid ? drv_level : '0;
      res.touch_consumed = consumed;
      res.is_fading      = nxt.fade_state == bifc_pkg::ST_FADING;
      res.is_dimmed      = nxt.fade_state == bifc_pkg::ST_DIMMED;
   end

endmodule

/* tb/backlight_idle_fade_controller_unit_tb.sv */
// Self-checking testbench for backlight_idle_fade_controller_unit.
// Depends on bifc_pkg, bifc_req_if and bifc_rsp_if; it predicts each
// result transaction in SystemVerilog and compares it with the block's output.
`timescale 1ns / 1ps

module backlight_idle_fade_controller_unit_tb;
   import bifc_pkg::*;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   bifc_req_if req_bus ();
   bifc_rsp_if rsp_bus ();

   backlight_idle_fade_controller_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Free-running 8 ns clock; the first rising edge comes at 4 ns.
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Predicted dimmer state. It mirrors what the block should hold after
   // every accepted transaction, using the package's one-hot state encoding.
   fade_state_type     dim_phase;
   logic               captured;
   logic [LEVEL_W-1:0] cur_level;
   logic [LEVEL_W-1:0] floor_level;
   logic [TIME_W-1:0]  activity_ms;
   logic [TIME_W-1:0]  step_ms;
   logic [TIME_W-1:0]  wake_ms;
   logic [MODE_W-1:0]  seen_mode;

   // Predicted copy of the configuration registers.
   logic                 cfg_enable;
   logic [DELAY_S_W-1:0] cfg_delay_s;
   logic [TARGET_W-1:0]  cfg_target;
   logic [LEVEL_W-1:0]   cfg_step;
   logic [LEVEL_W-1:0]   cfg_user;

   // Result being built for the transaction under prediction.
   result_type outcome;

   // Results still owed by the block, oldest first.
   result_type expected_drive[$];

   int mismatch_count = 0;
   int sender_gap_pct = 0;
   int receiver_stall_pct = 0;
   int activity_pct = 20;
   logic [TIME_W-1:0] clock_ms;

   function automatic void reset_predictor();
      dim_phase   = ST_WAIT;
      captured    = 1'b0;
      cur_level   = '0;
      floor_level = '0;
      activity_ms = '0;
      step_ms     = '0;
      wake_ms     = '0;
      seen_mode   = '0;
      cfg_enable  = FADE_ENABLE_RST;
      cfg_delay_s = 16'd30;
      cfg_target  = DIM_TARGET_RST;
      cfg_step    = FADE_STEP_RST;
      cfg_user    = NORMAL_LEVEL_RST;
   endfunction

   // The user brightness saturates at 100 percent wherever it is used.
   function automatic logic [LEVEL_W-1:0] user_brightness();
      return (cfg_user > LEVEL_MAX) ? LEVEL_MAX : cfg_user;
   endfunction

   // A wake restores the user brightness, but only drives it when a level was
   // captured and the backlight is not already there. It always rearms the
   // idle timer and the touch guard window.
   function automatic void wake_display(input logic [TIME_W-1:0] now);
      if (captured && cur_level != user_brightness()) begin
         outcome.drive_valid = 1'b1;
         outcome.drive_level = user_brightness();
      end
      wake_ms     = now;
      activity_ms = now;
      captured    = 1'b0;
      dim_phase   = ST_WAIT;
   endfunction

   function automatic void idle_tick(input item_type it);
      logic [TIME_W-1:0]  elapsed;
      logic [TIME_W-1:0]  idle_limit;
      logic [LEVEL_W-1:0] stride;
      logic [LEVEL_W-1:0] gap;
      // Access-point mode or a display that is not ready freezes the dimmer.
      if (it.soft_ap || !it.display_ready) return;
      if (!cfg_enable) begin
         if (dim_phase != ST_WAIT) wake_display(it.now_ms);
         return;
      end
      // A mode change counts as a wake; only the player mode dims.
      if (it.display_mode != seen_mode) begin
         seen_mode = it.display_mode;
         wake_display(it.now_ms);
      end
      if (it.display_mode != PLAYER_MODE) return;
      // A user brightness of zero is never captured, so the old level stays.
      if (!captured && user_brightness() > 0) begin
         cur_level = user_brightness();
         captured  = 1'b1;
      end
      case (dim_phase)
         ST_WAIT: begin
            elapsed    = it.now_ms - activity_ms;
            idle_limit = cfg_delay_s * MS_PER_S;
            if (elapsed > idle_limit) begin
               floor_level = (cfg_target > LEVEL_MAX) ? LEVEL_MAX : cfg_target[LEVEL_W-1:0];
               if (cur_level <= floor_level) begin
                  dim_phase = ST_DIMMED;
               end else begin
                  dim_phase = ST_FADING;
                  step_ms   = it.now_ms;
               end
            end
         end
         ST_FADING: begin
            elapsed = it.now_ms - step_ms;
            if (elapsed >= STEP_PERIOD_MS) begin
               step_ms = it.now_ms;
               if (cur_level > floor_level) begin
                  // A step of zero behaves as one; the last step lands on target.
                  stride    = (cfg_step == 0) ? LEVEL_ONE : cfg_step;
                  gap       = cur_level - floor_level;
                  cur_level = cur_level - ((stride < gap) ? stride : gap);
                  outcome.drive_valid = 1'b1;
                  outcome.drive_level = cur_level;
                  if (cur_level == floor_level) dim_phase = ST_DIMMED;
               end else begin
                  dim_phase = ST_DIMMED;
               end
            end
         end
         default: ;
      endcase
   endfunction

   // Works out the one result that an accepted transaction causes and
   // advances the predicted state.
   function automatic result_type advance_dimmer(input item_type it);
      logic [TIME_W-1:0] since_wake;
      outcome = '0;
      case (it.action)
         ACT_TICK: idle_tick(it);
         ACT_WAKE: wake_display(it.now_ms);
         ACT_TOUCH: begin
            // With dimming off a touch is ignored and never consumed.
            if (cfg_enable) begin
               if (dim_phase != ST_WAIT) begin
                  wake_display(it.now_ms);
                  outcome.touch_consumed = 1'b1;
               end else begin
                  activity_ms = it.now_ms;
                  since_wake  = it.now_ms - wake_ms;
                  if (since_wake < TOUCH_GUARD_MS) outcome.touch_consumed = 1'b1;
               end
            end
         end
         ACT_SET_ENABLE: begin
            // Disarming restores any captured level; arming only restores a
            // level that differs and also restarts the idle timer.
            if (!it.enable_value) begin
               if (captured) begin
                  outcome.drive_valid = 1'b1;
                  outcome.drive_level = user_brightness();
               end
            end else begin
               if (captured && cur_level != user_brightness()) begin
                  outcome.drive_valid = 1'b1;
                  outcome.drive_level = user_brightness();
               end
               activity_ms = it.now_ms;
            end
            captured  = 1'b0;
            dim_phase = ST_WAIT;
         end
         default: ;
      endcase
      outcome.is_fading = (dim_phase == ST_FADING);
      outcome.is_dimmed = (dim_phase == ST_DIMMED);
      return outcome;
   endfunction

   task automatic note_mismatch(input string why, input result_type want, input result_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t ns: %s: expected valid=%0b level=%0d consumed=%0b fading=%0b dimmed=%0b, got valid=%0b level=%0d consumed=%0b fading=%0b dimmed=%0b",
                  $time, why, want.drive_valid, want.drive_level, want.touch_consumed,
                  want.is_fading, want.is_dimmed, got.drive_valid, got.drive_level,
                  got.touch_consumed, got.is_fading, got.is_dimmed);
   endtask

   // Result checker: every accepted result transaction is compared field by
   // field with the oldest outstanding prediction.
   always @(posedge clock) begin : check_results
      result_type got;
      result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got.drive_valid    = rsp_bus.drive_valid;
         got.drive_level    = rsp_bus.drive_level;
         got.touch_consumed = rsp_bus.touch_consumed;
         got.is_fading      = rsp_bus.is_fading;
         got.is_dimmed      = rsp_bus.is_dimmed;
         if (expected_drive.size() == 0) begin
            note_mismatch("result with none outstanding", '0, got);
         end else begin
            want = expected_drive.pop_front();
            if (got.drive_valid !== want.drive_valid || got.drive_level !== want.drive_level ||
                got.touch_consumed !== want.touch_consumed ||
                got.is_fading !== want.is_fading || got.is_dimmed !== want.is_dimmed)
               note_mismatch("result mismatch", want, got);
         end
      end
   end

   // Receiver back-pressure, redrawn every cycle at the falling edge.
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Sends one request transaction. Valid is only lowered on idle cycles, so
   // back-to-back transactions keep it high without a second assignment.
   task automatic send_item(input item_type it);
      @(negedge clock);
      while ($urandom_range(99) < sender_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.action        <= it.action;
      req_bus.now_ms        <= it.now_ms;
      req_bus.soft_ap       <= it.soft_ap;
      req_bus.display_ready <= it.display_ready;
      req_bus.display_mode  <= it.display_mode;
      req_bus.enable_value  <= it.enable_value;
      req_bus.valid         <= 1'b1;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      expected_drive.push_back(advance_dimmer(it));
   endtask

   task automatic send_action(input action_type act, input logic [TIME_W-1:0] now,
                              input logic [MODE_W-1:0] mode = PLAYER_MODE,
                              input logic ap = 1'b0, input logic rdy = 1'b1,
                              input logic en = 1'b1);
      item_type it;
      it.action        = act;
      it.now_ms        = now;
      it.soft_ap       = ap;
      it.display_ready = rdy;
      it.display_mode  = mode;
      it.enable_value  = en;
      send_item(it);
   endtask

   // Stops sending and waits until every predicted result has arrived, then lets
   // the block's input and result registers settle before returning.
   task automatic wait_for_quiet();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_drive.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Writes all five registers; only called while the block is idle.
   task automatic apply_config(input logic en, input logic [DELAY_S_W-1:0] delay_s,
                               input logic [TARGET_W-1:0] target,
                               input logic [LEVEL_W-1:0] step,
                               input logic [LEVEL_W-1:0] user);
      write_csr(CSR_FADE_ENABLE, {15'd0, en});
      write_csr(CSR_IDLE_DELAY_S, delay_s);
      write_csr(CSR_DIM_TARGET, {8'd0, target});
      write_csr(CSR_FADE_STEP, {9'd0, step});
      write_csr(CSR_NORMAL_LEVEL, {9'd0, user});
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_enable  = en;
      cfg_delay_s = delay_s;
      cfg_target  = target;
      cfg_step    = step;
      cfg_user    = user;
   endtask

   // Short scripted sequences: disabled dimming, the full fade cycle, the
   // touch guard window, mode changes, saturation of both levels, a zero user
   // brightness, a zero and a full-size step, and disabling while dimmed.
   task automatic test_directed();
      // Dimming is off after reset: a tick does nothing, a touch is not consumed.
      send_action(ACT_TICK, 32'd0);
      send_action(ACT_TOUCH, 32'd0);
      wait_for_quiet();

      // Immediate fade towards 90 with a zero step, which acts as one.
      apply_config(1'b1, 16'd0, 8'd90, 7'd0, 7'd100);
      send_action(ACT_SET_ENABLE, 32'd1000);
      send_action(ACT_TICK, 32'd1000);
      send_action(ACT_TICK, 32'd1001);
      send_action(ACT_TICK, 32'd1030);
      send_action(ACT_TICK, 32'd1051);
      send_action(ACT_TICK, 32'd1101);
      // A touch while fading wakes and is consumed; the next one falls in the
      // guard window, and one after the window is passed on.
      send_action(ACT_TOUCH, 32'd1110);
      send_action(ACT_TOUCH, 32'd1200);
      send_action(ACT_TOUCH, 32'd1700);
      send_action(ACT_TICK, 32'd1710, PLAYER_MODE, 1'b1);
      send_action(ACT_TICK, 32'd1720, PLAYER_MODE, 1'b0, 1'b0);
      send_action(ACT_TICK, 32'd1800, 4'hF);
      send_action(ACT_TICK, 32'd1801);
      send_action(ACT_TICK, 32'd1802);
      send_action(ACT_SET_ENABLE, 32'd1803, PLAYER_MODE, 1'b0, 1'b1, 1'b0);
      wait_for_quiet();

      // Target above 100 and user level above 100 both saturate, so the
      // captured level already meets the target and the block dims at once.
      apply_config(1'b1, 16'd0, 8'd255, 7'd127, 7'd127);
      send_action(ACT_SET_ENABLE, 32'd5000);
      send_action(ACT_TICK, 32'd5001);
      send_action(ACT_WAKE, 32'd5002);
      send_action(ACT_TICK, 32'd5003);
      wait_for_quiet();

      // A zero user level is never captured; one full step goes to zero.
      apply_config(1'b1, 16'd0, 8'd0, 7'd100, 7'd0);
      send_action(ACT_SET_ENABLE, 32'd6000);
      send_action(ACT_TICK, 32'd6001);
      send_action(ACT_TICK, 32'd6051);
      wait_for_quiet();

      // Turning dimming off while dimmed wakes on the next tick.
      apply_config(1'b0, 16'd0, 8'd0, 7'd100, 7'd0);
      send_action(ACT_TICK, 32'd6100);
   endtask

   // The longest idle delay, including the exact boundary where the elapsed
   // time equals the delay and the first millisecond past it.
   task automatic test_long_idle_delay();
      wait_for_quiet();
      apply_config(1'b1, 16'hFFFF, 8'hFF, 7'h7F, 7'd50);
      send_action(ACT_SET_ENABLE, 32'd0);
      send_action(ACT_TICK, 32'd65_535_000);
      send_action(ACT_TICK, 32'd65_535_001);
      repeat (27) begin
         if ($urandom_range(3) == 0) send_action(ACT_SET_ENABLE, $urandom());
         else send_action(ACT_TICK, $urandom());
      end
   endtask

   // Mostly well-formed traffic in the player mode with an advancing clock,
   // so that the dimmer reaches fading and dimmed; the rest is pure noise.
   function automatic item_type random_item();
      item_type it;
      int pick;
      if ($urandom_range(99) < 10) begin
         it.action        = action_type'($urandom_range(3));
         it.now_ms        = $urandom();
         it.soft_ap       = $urandom_range(1);
         it.display_ready = $urandom_range(1);
         it.display_mode  = $urandom_range(15);
         it.enable_value  = $urandom_range(1);
         return it;
      end
      // Occasional long pauses let the idle delay expire.
      if ($urandom_range(99) < 4) clock_ms = clock_ms + $urandom_range(1000, 3000);
      else clock_ms = clock_ms + $urandom_range(120);
      it.now_ms = clock_ms;
      pick = $urandom_range(99);
      if (pick >= activity_pct) it.action = ACT_TICK;
      else if (pick < activity_pct / 2) it.action = ACT_TOUCH;
      else if (pick < (3 * activity_pct) / 4) it.action = ACT_SET_ENABLE;
      else it.action = ACT_WAKE;
      it.soft_ap       = ($urandom_range(99) < 4);
      it.display_ready = ($urandom_range(99) >= 4);
      it.display_mode  = ($urandom_range(99) < 92) ? PLAYER_MODE : $urandom_range(15);
      it.enable_value  = ($urandom_range(99) < 75);
      return it;
   endfunction

   task automatic pick_config();
      logic                 en;
      logic [DELAY_S_W-1:0] delay_s;
      logic [TARGET_W-1:0]  target;
      logic [LEVEL_W-1:0]   step;
      logic [LEVEL_W-1:0]   user;
      en = ($urandom_range(99) < 85);
      case ($urandom_range(9))
         0, 1, 2, 3: delay_s = 16'd0;
         4, 5, 6:    delay_s = 16'd1;
         7:          delay_s = 16'd2;
         8:          delay_s = 16'hFFFF;
         default:    delay_s = $urandom();
      endcase
      target = $urandom_range(255);
      step   = $urandom_range(1) ? $urandom_range(127) : $urandom_range(4);
      user   = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(100);
      apply_config(en, delay_s, target, step, user);
   endtask

   // One idling phase: a few segments, each with its own configuration and a
   // clock that sometimes starts just short of the 32-bit wrap.
   task automatic test_random_phase(input int gap_pct, input int stall_pct);
      wait_for_quiet();
      sender_gap_pct     = gap_pct;
      receiver_stall_pct = stall_pct;
      repeat (3) begin
         wait_for_quiet();
         pick_config();
         activity_pct = $urandom_range(1) ? 4 : 20;
         clock_ms = ($urandom_range(9) < 3) ? 32'hFFFF_FFFF - $urandom_range(2000) : $urandom();
         repeat (84) send_item(random_item());
      end
   endtask

   // Main sequence: reset once, then the directed checks, then four idling
   // phases of random traffic, then a drain before the verdict.
   initial begin
      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_index             = '0;
      csr_wdata             = '0;
      req_bus.valid         = 1'b0;
      req_bus.action        = '0;
      req_bus.now_ms        = '0;
      req_bus.soft_ap       = 1'b0;
      req_bus.display_ready = 1'b0;
      req_bus.display_mode  = '0;
      req_bus.enable_value  = 1'b0;
      rsp_bus.ready         = 1'b1;
      clock_ms              = '0;
      reset_predictor();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_long_idle_delay();
      test_random_phase(0, 0);
      test_random_phase(62, 0);
      test_random_phase(0, 62);
      test_random_phase(28, 28);
      wait_for_quiet();

      if (mismatch_count == 0) begin
         $display("** backlight_idle_fade_controller_unit: PASSED **");
      end else begin
         $display("** backlight_idle_fade_controller_unit: FAILED **");
      end
      $finish;
   end

   // Watchdog: a correct run needs a small fraction of this time.
   initial begin
      #5_000_000;
      $display("** backlight_idle_fade_controller_unit: FAILED **");
      $finish;
   end

endmodule
